FILE: hw/rtl/binned_pair_stat_accumulator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binned pair statistics accumulator
// Concurrent checks on a clock with an active-low asynchronous reset
// ----------------------------------------------------------------------------
`ifndef BINNED_PAIR_STAT_ACCUMULATOR_TOP_ASSERT_SVH
`define BINNED_PAIR_STAT_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BPSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define BPSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/bpsa_pkg.sv
// ----------------------------------------------------------------------------
// bpsa_pkg
// Shared types and constants of the binned pair statistics accumulator
// ----------------------------------------------------------------------------
`default_nettype none
package bpsa_pkg;

  // widest cell address, for up to 1024 bins per axis
  localparam int CELL_AW_MAX = 20;
  localparam int OPQ_DEPTH   = 2;
  localparam logic [30:0] BIN_WIDTH_RST = 31'd1000000;
  localparam logic [47:0] TESTED_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_COUNTED   = 3'd0,
    ST_TOO_CLOSE = 3'd1,
    ST_TOO_FAR   = 3'd2,
    ST_INVALID   = 3'd3,
    ST_RANGE     = 3'd4,
    ST_READ      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_INTRA_MODE   = 2'd0,
    CFG_BIN_WIDTH    = 2'd1,
    CFG_MIN_DISTANCE = 2'd2,
    CFG_MAX_DISTANCE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_READ   = 2'd1,
    OP_ACC    = 2'd2
  } op_kind_e;

  typedef enum logic [1:0] {
    FE_IDLE     = 2'd0,
    FE_CLASSIFY = 2'd1,
    FE_DIV      = 2'd2,
    FE_PUSH     = 2'd3
  } fe_state_e;

  typedef enum logic [2:0] {
    BE_CLEAR = 3'd0,
    BE_IDLE  = 3'd1,
    BE_READ  = 3'd2,
    BE_DIV   = 3'd3,
    BE_MUL   = 3'd4,
    BE_ADD   = 3'd5
  } be_state_e;

  typedef struct packed {
    op_kind_e                kind;
    status_e                 status;
    logic                    inc_tested;
    logic [CELL_AW_MAX-1:0]  addr;
    logic signed [17:0]      corr;
  } op_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bpsa_ram.sv
// ----------------------------------------------------------------------------
// bpsa_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module bpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bpsa_div.sv
// ----------------------------------------------------------------------------
// bpsa_div
// Restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module bpsa_div #(
  parameter int W_N = 32,
  parameter int W_D = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W_N-1:0] dividend_i,
  input  wire logic [W_D-1:0] divisor_i,
  output logic                done_o,
  output logic      [W_N-1:0] quotient_o
);
  localparam int CW = $clog2(W_N + 1);

  logic           busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [W_N-1:0] quo_q, quo_d;
  logic [W_D-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [W_D:0]   rem_sh, diff;
  logic           ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[W_N-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CW'(W_N);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[W_N-2:0], ge};
      rem_d = ge ? diff[W_D-1:0] : rem_sh[W_D-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

FILE: hw/rtl/bpsa_fifo.sv
// ----------------------------------------------------------------------------
// bpsa_fifo
// Short operation queue between the classifying front and the cell back end
// ----------------------------------------------------------------------------
`default_nettype none
module bpsa_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bpsa_pkg::op_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output bpsa_pkg::op_t      data_o,
  output logic               empty_o
);
  import bpsa_pkg::*;

  localparam int PW = $clog2(OPQ_DEPTH);

  op_t             mem_q [OPQ_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;

  assign full_o  = cnt_q == (PW+1)'(OPQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(OPQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(OPQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bpsa_front.sv
// ----------------------------------------------------------------------------
// bpsa_front
// Takes input beats, applies distance and validity filters, bins positions or passes on cell reads
// ----------------------------------------------------------------------------
`default_nettype none
module bpsa_front #(
  parameter int BINS_PER_AXIS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               clr_busy_i,
  input  wire logic               opcode_i,
  input  wire logic signed [17:0] corr_value_i,
  input  wire logic               corr_valid_i,
  input  wire logic [30:0]        pos_a_i,
  input  wire logic [30:0]        pos_b_i,
  input  wire logic [5:0]         cell_row_i,
  input  wire logic [5:0]         cell_col_i,
  output logic                    op_push_o,
  output bpsa_pkg::op_t           op_o,
  input  wire logic               op_full_i
);
  import bpsa_pkg::*;

  fe_state_e          state_q, state_d;
  logic               intra_q;
  logic [30:0]        bw_q;
  logic [31:0]        min_q, max_q;
  logic               opc_q, vld_q;
  logic signed [17:0] corr_q;
  logic [30:0]        pa_q, pb_q;
  logic [5:0]         row_q, col_q;
  op_t                op_q, op_d;
  logic               div_start, div_done;
  logic [30:0]        qa, qb;
  logic signed [32:0] gap, mx, mn;
  logic               too_far, too_close;

  assign full = (state_q != FE_IDLE) || clr_busy_i;

  always_comb begin
    gap       = $signed({2'b00, pb_q}) - $signed({2'b00, pa_q});
    mx        = $signed({max_q[31], max_q});
    mn        = $signed({min_q[31], min_q});
    too_far   = intra_q && !max_q[31] && (gap > mx);
    too_close = intra_q && !min_q[31] && (gap < mn);
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    div_start  = 1'b0;
    op_push_o  = 1'b0;
    unique case (state_q)
      FE_IDLE: begin
        if (push && !full) begin
          state_d = FE_CLASSIFY;
        end
      end
      FE_CLASSIFY: begin
        op_d.corr       = corr_q;
        op_d.kind       = OP_REPORT;
        op_d.inc_tested = 1'b0;
        op_d.addr       = '0;
        op_d.status     = ST_COUNTED;
        state_d         = FE_PUSH;
        if (opc_q) begin
          if (32'(row_q) >= 32'(BINS_PER_AXIS) || 32'(col_q) >= 32'(BINS_PER_AXIS)) begin
            op_d.status = ST_RANGE;
          end else begin
            op_d.kind   = OP_READ;
            op_d.status = ST_READ;
            op_d.addr   = CELL_AW_MAX'(32'(row_q) * 32'(BINS_PER_AXIS) + 32'(col_q));
          end
        end else if (too_far) begin
          op_d.status = ST_TOO_FAR;
        end else if (too_close) begin
          op_d.status = ST_TOO_CLOSE;
        end else if (!vld_q) begin
          op_d.status = ST_INVALID;
        end else begin
          div_start = 1'b1;
          state_d   = FE_DIV;
        end
      end
      FE_DIV: begin
        if (div_done) begin
          op_d.inc_tested = 1'b1;
          if (32'(qa) >= 32'(BINS_PER_AXIS) || 32'(qb) >= 32'(BINS_PER_AXIS)) begin
            op_d.status = ST_RANGE;
          end else begin
            op_d.kind   = OP_ACC;
            op_d.status = ST_COUNTED;
            op_d.addr   = CELL_AW_MAX'(32'(qa) * 32'(BINS_PER_AXIS) + 32'(qb));
          end
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!op_full_i) begin
          op_push_o = 1'b1;
          state_d   = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  assign op_o = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      intra_q <= 1'b1;
      bw_q    <= BIN_WIDTH_RST;
      min_q   <= '1;
      max_q   <= '1;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_INTRA_MODE:   intra_q <= cfg_data_i[0];
          CFG_BIN_WIDTH:    bw_q    <= cfg_data_i[30:0];
          CFG_MIN_DISTANCE: min_q   <= cfg_data_i;
          CFG_MAX_DISTANCE: max_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (state_q == FE_IDLE && push && !full) begin
      opc_q  <= opcode_i;
      corr_q <= corr_value_i;
      vld_q  <= corr_valid_i;
      pa_q   <= pos_a_i;
      pb_q   <= pos_b_i;
      row_q  <= cell_row_i;
      col_q  <= cell_col_i;
    end
  end

  // both positions are binned in parallel and finish together
  bpsa_div #(.W_N(31), .W_D(31)) u_div_a (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(pa_q), .divisor_i(bw_q),
    .done_o(div_done), .quotient_o(qa)
  );

  bpsa_div #(.W_N(31), .W_D(31)) u_div_b (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(pb_q), .divisor_i(bw_q),
    .done_o(), .quotient_o(qb)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/bpsa_back.sv
// ----------------------------------------------------------------------------
// bpsa_back
// Cell store, Welford update, read-and-clear and the result register
// ----------------------------------------------------------------------------
`default_nettype none
module bpsa_back #(
  parameter int BINS_PER_AXIS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bpsa_pkg::op_t op_i,
  input  wire logic          op_empty_i,
  output logic               op_pop_o,
  output logic               clr_busy_o,
  output logic               empty,
  input  wire logic          pop,
  output logic [2:0]         status_o,
  output logic [31:0]        cell_count_o,
  output logic [31:0]        cell_mean_o,
  output logic [63:0]        cell_m2_o,
  output logic [47:0]        tested_total_o
);
  import bpsa_pkg::*;

  localparam int NUM_CELLS = BINS_PER_AXIS * BINS_PER_AXIS;
  localparam int CAW       = $clog2(NUM_CELLS);

  be_state_e          state_q, state_d;
  logic [CAW-1:0]     clr_q, clr_d;
  logic [47:0]        tested_q, tested_d;
  op_t                cur_q, cur_d;
  logic               ov_q, ov_d;
  logic [2:0]         ost_q, ost_d;
  logic [31:0]        ocnt_q, ocnt_d, omean_q, omean_d;
  logic [63:0]        om2_q, om2_d;
  logic [47:0]        otst_q, otst_d;
  logic [31:0]        n_q, n_d, mean_q, mean_d, nm_q, nm_d;
  logic [63:0]        m2_q, m2_d, prod_q, prod_d;
  logic signed [25:0] x_q, x_d;
  logic               neg_q, neg_d;
  logic [31:0]        d1_q, d1_d, d2_q, d2_d;
  logic               we, div_start, div_done;
  logic [CAW-1:0]     waddr;
  logic [127:0]       wdata, rdata;
  logic [31:0]        quo;
  logic signed [33:0] xs, ms, d1s, d1n, qs, nm34, d2s, d2n;
  logic [64:0]        m2sum;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    tested_d  = tested_q;
    cur_d     = cur_q;
    ov_d      = ov_q && !pop;
    ost_d     = ost_q;
    ocnt_d    = ocnt_q;
    omean_d   = omean_q;
    om2_d     = om2_q;
    otst_d    = otst_q;
    n_d       = n_q;
    mean_d    = mean_q;
    nm_d      = nm_q;
    m2_d      = m2_q;
    prod_d    = prod_q;
    x_d       = x_q;
    neg_d     = neg_q;
    d1_d      = d1_q;
    d2_d      = d2_q;
    we        = 1'b0;
    waddr     = cur_q.addr[CAW-1:0];
    wdata     = '0;
    div_start = 1'b0;
    op_pop_o  = 1'b0;
    // welford arithmetic on 34-bit signed values
    xs    = $signed({{8{cur_q.corr[17]}}, cur_q.corr, 8'b0});
    ms    = $signed({{2{rdata[63]}}, rdata[63:32]});
    d1s   = xs - ms;
    d1n   = -d1s;
    qs    = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    nm34  = $signed({{2{mean_q[31]}}, mean_q}) + qs;
    d2s   = $signed({{8{x_q[25]}}, x_q}) - $signed({{2{nm34[31]}}, nm34[31:0]});
    d2n   = -d2s;
    m2sum = {1'b0, m2_q} + {17'b0, prod_q[63:16]};
    unique case (state_q)
      BE_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == CAW'(NUM_CELLS - 1)) begin
          state_d = BE_IDLE;
        end
      end
      BE_IDLE: begin
        if (!op_empty_i && !ov_q) begin
          op_pop_o = 1'b1;
          cur_d    = op_i;
          if (op_i.inc_tested && tested_q != TESTED_MAX) begin
            tested_d = tested_q + 1'b1;
          end
          if (op_i.kind == OP_REPORT) begin
            ov_d    = 1'b1;
            ost_d   = op_i.status;
            ocnt_d  = '0;
            omean_d = '0;
            om2_d   = '0;
            otst_d  = tested_d;
          end else begin
            state_d = BE_READ;
          end
        end
      end
      BE_READ: begin
        if (cur_q.kind == OP_READ) begin
          we      = 1'b1;
          ov_d    = 1'b1;
          ost_d   = ST_READ;
          ocnt_d  = rdata[31:0];
          omean_d = rdata[63:32];
          om2_d   = rdata[127:64];
          otst_d  = tested_q;
          state_d = BE_IDLE;
        end else begin
          n_d       = (rdata[31:0] == COUNT_MAX) ? rdata[31:0] : rdata[31:0] + 1'b1;
          mean_d    = rdata[63:32];
          m2_d      = rdata[127:64];
          x_d       = xs[25:0];
          neg_d     = d1s[33];
          d1_d      = d1s[33] ? d1n[31:0] : d1s[31:0];
          div_start = 1'b1;
          state_d   = BE_DIV;
        end
      end
      BE_DIV: begin
        if (div_done) begin
          nm_d    = nm34[31:0];
          d2_d    = neg_q ? d2n[31:0] : d2s[31:0];
          state_d = BE_MUL;
        end
      end
      BE_MUL: begin
        prod_d  = 64'(d1_q) * 64'(d2_q);
        state_d = BE_ADD;
      end
      BE_ADD: begin
        m2_d    = m2sum[64] ? '1 : m2sum[63:0];
        we      = 1'b1;
        wdata   = {m2_d, nm_q, n_q};
        ov_d    = 1'b1;
        ost_d   = ST_COUNTED;
        ocnt_d  = n_q;
        omean_d = nm_q;
        om2_d   = m2_d;
        otst_d  = tested_q;
        state_d = BE_IDLE;
      end
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BE_CLEAR;
      clr_q    <= '0;
      tested_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      tested_q <= tested_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ost_q   <= ost_d;
    ocnt_q  <= ocnt_d;
    omean_q <= omean_d;
    om2_q   <= om2_d;
    otst_q  <= otst_d;
    n_q     <= n_d;
    mean_q  <= mean_d;
    nm_q    <= nm_d;
    m2_q    <= m2_d;
    prod_q  <= prod_d;
    x_q     <= x_d;
    neg_q   <= neg_d;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
  end

  assign clr_busy_o     = state_q == BE_CLEAR;
  assign empty          = !ov_q;
  assign status_o       = ost_q;
  assign cell_count_o   = ocnt_q;
  assign cell_mean_o    = omean_q;
  assign cell_m2_o      = om2_q;
  assign tested_total_o = otst_q;

  // count, mean and m2 of a cell share one word
  bpsa_ram #(.WIDTH(128), .DEPTH(NUM_CELLS)) u_cells (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(op_i.addr[CAW-1:0]), .rdata_o(rdata)
  );

  // operands are taken on the start edge, straight from the read stage
  bpsa_div #(.W_N(32), .W_D(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(d1_d), .divisor_i(n_d),
    .done_o(div_done), .quotient_o(quo)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/binned_pair_stat_accumulator_top.sv
// ----------------------------------------------------------------------------
// binned_pair_stat_accumulator_top
// Per-cell running count, mean and M2 of pair correlations on a 2-D bin grid
// ----------------------------------------------------------------------------
// After reset the cell store is swept to zero, one cell per cycle, over all
// BINS_PER_AXIS*BINS_PER_AXIS cells (4096 at the default); full stays high
// meanwhile, configuration writes are taken at any time. The front takes one
// beat, filters it and bins both positions with two 31-bit dividers, then
// hands an operation to a two-entry queue. The back end reads the cell and,
// for a counted pair, runs the mean update through a 32-bit divider, a
// multiply and a saturating add; a report is answered from the idle state
// and a read-and-clear from the read state. The front works on the next beat
// while the back end finishes, so the sustained rate for counted pairs is
// set by the back-end divider. A finished result waits in the output
// register and the back end takes no new operation until it is popped,
// while the queue and the front keep filling.
`default_nettype none
module binned_pair_stat_accumulator_top #(
  parameter int BINS_PER_AXIS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // input beats
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode_i,
  input  wire logic signed [17:0] corr_value_i,
  input  wire logic               corr_valid_i,
  input  wire logic [30:0]        pos_a_i,
  input  wire logic [30:0]        pos_b_i,
  input  wire logic [5:0]         cell_row_i,
  input  wire logic [5:0]         cell_col_i,
  // result beats
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              status_o,
  output logic [31:0]             cell_count_o,
  output logic signed [31:0]      cell_mean_o,
  output logic [63:0]             cell_m2_o,
  output logic [47:0]             tested_total_o
);
  import bpsa_pkg::*;

  `include "binned_pair_stat_accumulator_top_assert.svh"

  op_t  q_in, q_out;
  logic q_push, q_full, q_pop, q_empty, clr_busy;
  logic [31:0] mean_raw;

  // registers are plain flops, a write always lands
  assign cfg_ready_o = 1'b1;
  assign cell_mean_o = $signed(mean_raw);

  bpsa_front #(.BINS_PER_AXIS(BINS_PER_AXIS)) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .push, .full, .clr_busy_i(clr_busy),
    .opcode_i, .corr_value_i, .corr_valid_i, .pos_a_i, .pos_b_i,
    .cell_row_i, .cell_col_i,
    .op_push_o(q_push), .op_o(q_in), .op_full_i(q_full)
  );

  bpsa_fifo u_opq (
    .clk_i, .rst_ni,
    .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .data_o(q_out), .empty_o(q_empty)
  );

  bpsa_back #(.BINS_PER_AXIS(BINS_PER_AXIS)) u_back (
    .clk_i, .rst_ni,
    .op_i(q_out), .op_empty_i(q_empty), .op_pop_o(q_pop), .clr_busy_o(clr_busy),
    .empty, .pop,
    .status_o, .cell_count_o, .cell_mean_o(mean_raw), .cell_m2_o, .tested_total_o
  );

  // no beat enters while the cell store is being swept
  `BPSA_ASSERT_NOW(a_clear_blocks_input, clk_i, rst_ni, clr_busy, full, "beat taken during clear")
  // the front never pushes into a full queue
  `BPSA_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, q_push, !q_full, "operation queue overflow")
  // the back end never pops an empty queue
  `BPSA_ASSERT_NOW(a_no_underflow, clk_i, rst_ni, q_pop, !q_empty, "operation queue underflow")
  // a pop by the back end with a result waiting would lose it
  `BPSA_ASSERT_NEXT(a_pop_then_result, clk_i, rst_ni, q_pop && !empty && !pop, !empty, "result lost")
endmodule
`default_nettype wire

FILE: bench/bpsa_checker.sv
// ----------------------------------------------------------------------------
// bpsa_checker
// Watches the configuration, input and result channels of the accumulator,
// keeps its own copy of the cell grid and compares every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpsa_checker
  import bpsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic               opcode_i,
  input  logic signed [17:0] corr_value_i,
  input  logic               corr_valid_i,
  input  logic [30:0]        pos_a_i,
  input  logic [30:0]        pos_b_i,
  input  logic [5:0]         cell_row_i,
  input  logic [5:0]         cell_col_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [2:0]         status_i,
  input  logic [31:0]        cell_count_i,
  input  logic [31:0]        cell_mean_i,
  input  logic [63:0]        cell_m2_i,
  input  logic [47:0]        tested_total_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 counted_o,
  output int                 reads_o
);

  localparam int BINS  = 64;
  localparam int CELLS = BINS * BINS;

  typedef struct packed {
    status_e     status;
    logic [31:0] cnt;
    logic [31:0] mean;
    logic [63:0] m2;
    logic [47:0] tested;
  } cell_report_t;

  logic [31:0] cnt_mem [CELLS];
  logic [31:0] mean_mem[CELLS];
  logic [63:0] m2_mem  [CELLS];
  logic [47:0] tested_cnt;

  logic        intra_q;
  logic [30:0] bin_w_q;
  logic [31:0] min_d_q;
  logic [31:0] max_d_q;

  cell_report_t expected_reports[$];

  assign pending_o = expected_reports.size();

  function automatic cell_report_t blank(status_e st);
    cell_report_t r;
    r = '0;
    r.status = st;
    r.tested = tested_cnt;
    return r;
  endfunction

  task automatic predict_beat(output cell_report_t r);
    longint gap, mx, mn, x, mean, d1, d2, nm;
    logic [63:0] n, inc, m2, ba, bb;
    int a;
    if (opcode_i) begin
      a = cell_row_i * BINS + cell_col_i;
      r = blank(ST_READ);
      r.cnt = cnt_mem[a];
      r.mean = mean_mem[a];
      r.m2 = m2_mem[a];
      cnt_mem[a] = '0;
      mean_mem[a] = '0;
      m2_mem[a] = '0;
      reads_o++;
      return;
    end
    if (intra_q) begin
      gap = longint'({33'd0, pos_b_i}) - longint'({33'd0, pos_a_i});
      mx = longint'($signed(max_d_q));
      mn = longint'($signed(min_d_q));
      if (mx >= 0 && gap > mx) begin
        r = blank(ST_TOO_FAR);
        return;
      end
      if (mn >= 0 && gap < mn) begin
        r = blank(ST_TOO_CLOSE);
        return;
      end
    end
    if (!corr_valid_i) begin
      r = blank(ST_INVALID);
      return;
    end
    if (tested_cnt != TESTED_MAX) tested_cnt++;
    if (bin_w_q == '0) begin
      ba = '1;
      bb = '1;
    end else begin
      ba = 64'(pos_a_i / bin_w_q);
      bb = 64'(pos_b_i / bin_w_q);
    end
    if (ba >= BINS || bb >= BINS) begin
      r = blank(ST_RANGE);
      return;
    end
    a = int'(ba) * BINS + int'(bb);
    n = 64'(cnt_mem[a]);
    if (n < 64'(COUNT_MAX)) n++;
    x = longint'(corr_value_i) * 256;
    mean = longint'($signed(mean_mem[a]));
    d1 = x - mean;
    nm = mean + d1 / longint'(n);
    d2 = x - nm;
    // both deltas share a sign, so fold onto the positive side
    if (d1 < 0) begin
      d1 = -d1;
      d2 = -d2;
    end
    inc = (64'(d1) * 64'(d2)) >> 16;
    m2 = m2_mem[a];
    m2 = (m2 > ~inc) ? '1 : m2 + inc;
    cnt_mem[a] = n[31:0];
    mean_mem[a] = nm[31:0];
    m2_mem[a] = m2;
    r = blank(ST_COUNTED);
    r.cnt = n[31:0];
    r.mean = nm[31:0];
    r.m2 = m2;
    counted_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_report_t exp_r, got_r;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        cnt_mem[i] = '0;
        mean_mem[i] = '0;
        m2_mem[i] = '0;
      end
      tested_cnt = '0;
      intra_q = 1'b1;
      bin_w_q = BIN_WIDTH_RST;
      min_d_q = '1;
      max_d_q = '1;
      expected_reports.delete();
      fail_count_o = 0;
      counted_o = 0;
      reads_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_INTRA_MODE:   intra_q = cfg_data_i[0];
          CFG_BIN_WIDTH:    bin_w_q = cfg_data_i[30:0];
          CFG_MIN_DISTANCE: min_d_q = cfg_data_i;
          CFG_MAX_DISTANCE: max_d_q = cfg_data_i;
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        got_r = {status_e'(status_i), cell_count_i, cell_mean_i, cell_m2_i, tested_total_i};
        if (expected_reports.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] result beat with nothing expected: %p", $realtime, got_r);
        end else begin
          exp_r = expected_reports.pop_front();
          if (got_r !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("[%0t] mismatch\n  expected %p\n  actual   %p", $realtime, exp_r,
                       got_r);
          end
        end
      end
      if (push_i && !full_i) begin
        predict_beat(exp_r);
        expected_reports.insert(expected_reports.size(), exp_r);
      end
    end
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random pair beats through the binned accumulator under
// several register settings and idle patterns; the checker predicts each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import bpsa_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int SEGMENTS     = 6;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic               push = 1'b0;
  logic               full;
  logic               opcode_i = 1'b0;
  logic signed [17:0] corr_value_i = '0;
  logic               corr_valid_i = 1'b0;
  logic [30:0]        pos_a_i = '0;
  logic [30:0]        pos_b_i = '0;
  logic [5:0]         cell_row_i = '0;
  logic [5:0]         cell_col_i = '0;

  logic               empty;
  logic               pop = 1'b0;
  logic [2:0]         status_o;
  logic [31:0]        cell_count_o;
  logic signed [31:0] cell_mean_o;
  logic [63:0]        cell_m2_o;
  logic [47:0]        tested_total_o;

  int fail_count, pending_reports, counted_pairs, cell_reads;

  // idle percentages, changed every two segments
  int send_idle_pct = 31;
  int recv_idle_pct = 88;
  longint cycle_cnt = 0;

  // current bin width, so random positions land mostly inside the grid
  logic [30:0] cur_bin_w = BIN_WIDTH_RST;

  always #2ns clk_i = ~clk_i;

  binned_pair_stat_accumulator_top dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push, .full, .opcode_i, .corr_value_i, .corr_valid_i,
    .pos_a_i, .pos_b_i, .cell_row_i, .cell_col_i,
    .empty, .pop, .status_o, .cell_count_o, .cell_mean_o, .cell_m2_o,
    .tested_total_o
  );

  bpsa_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .push_i(push), .full_i(full), .opcode_i, .corr_value_i, .corr_valid_i,
    .pos_a_i, .pos_b_i, .cell_row_i, .cell_col_i,
    .empty_i(empty), .pop_i(pop), .status_i(status_o), .cell_count_i(cell_count_o),
    .cell_mean_i(cell_mean_o), .cell_m2_i(cell_m2_o), .tested_total_i(tested_total_o),
    .fail_count_o(fail_count), .pending_o(pending_reports),
    .counted_o(counted_pairs), .reads_o(cell_reads)
  );

  // receiver side: random stalls on pop
  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog, sized for the clearing sweep plus the slowest beats under stall
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one register write beat
  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_BIN_WIDTH) cur_bin_w = data[30:0];
  endtask

  task automatic apply_setting(logic intra, logic [31:0] bw, logic [31:0] mn,
                               logic [31:0] mx);
    write_reg(CFG_INTRA_MODE, {31'd0, intra});
    write_reg(CFG_BIN_WIDTH, bw);
    write_reg(CFG_MIN_DISTANCE, mn);
    write_reg(CFG_MAX_DISTANCE, mx);
  endtask

  // one input beat; push stays high after acceptance until the next idle
  task automatic send_beat(logic op, logic signed [17:0] corr, logic vld,
                           logic [30:0] pa, logic [30:0] pb, logic [5:0] row,
                           logic [5:0] col);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    opcode_i     <= op;
    corr_value_i <= corr;
    corr_valid_i <= vld;
    pos_a_i      <= pa;
    pos_b_i      <= pb;
    cell_row_i   <= row;
    cell_col_i   <= col;
    do @(posedge clk_i); while (full);
  endtask

  // wait until every result is back, then let the back end settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_reports != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // position inside the grid for the current bin width, or anywhere now and then
  function automatic logic [30:0] grid_pos(logic [5:0] bin);
    longint span, p;
    if ($urandom_range(0, 19) == 0) return 31'($urandom());
    span = longint'(cur_bin_w);
    p = longint'(bin) * span + longint'($urandom()) % span;
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    return 31'(p);
  endfunction

  task automatic random_beat();
    logic [5:0] ra, rb;
    logic [30:0] pa, pb;
    logic signed [17:0] corr;
    // a few hot rows so cells build up real statistics
    ra = ($urandom_range(0, 2) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 3));
    rb = ($urandom_range(0, 2) == 0) ? 6'($urandom()) : ra + 6'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 12) begin
      send_beat(1'b1, 18'($urandom()), 1'($urandom()), 31'($urandom()), 31'($urandom()),
                ra, rb);
    end else begin
      pa = grid_pos(ra);
      pb = grid_pos(rb);
      corr = ($urandom_range(0, 9) == 0) ? 18'($urandom())
                                         : 18'sd16384 + 18'($urandom_range(0, 20000)) - 18'sd10000;
      send_beat(1'b0, corr, $urandom_range(0, 9) != 0, pa, pb, 6'($urandom()),
                6'($urandom()));
    end
  endtask

  initial begin
    logic [31:0] bw_set [SEGMENTS] = '{32'd1, 32'h7FFF_FFFF, 32'd1000, 32'd500, 32'd37,
                                       32'd1000000};
    logic [31:0] mn_set [SEGMENTS] = '{32'hFFFF_FFFF, 32'd0, 32'd100, 32'h7FFF_FFFF,
                                       32'd2, 32'hFFFF_FFFF};
    logic [31:0] mx_set [SEGMENTS] = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd30000,
                                       32'hFFFF_FFFF, 32'd900, 32'd0};
    logic        in_set [SEGMENTS] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: bin width 16, gap window 4..200
    apply_setting(1'b1, 32'd16, 32'd4, 32'd200);
    send_beat(1'b0, 18'sd65536, 1'b1, 31'd0, 31'd16, 6'd0, 6'd0);       // counted
    send_beat(1'b0, -18'sd131072, 1'b1, 31'd1, 31'd20, 6'd0, 6'd0);     // same cell
    send_beat(1'b0, 18'sd131071, 1'b1, 31'd2, 31'd30, 6'd0, 6'd0);      // same cell
    send_beat(1'b0, 18'sd0, 1'b1, 31'd0, 31'd201, 6'd0, 6'd0);          // too far
    send_beat(1'b0, 18'sd0, 1'b1, 31'd100, 31'd103, 6'd0, 6'd0);        // too close
    send_beat(1'b0, 18'sd0, 1'b1, 31'd100, 31'd50, 6'd0, 6'd0);         // negative gap
    send_beat(1'b0, 18'sd0, 1'b0, 31'd0, 31'd100, 6'd0, 6'd0);          // invalid
    // invalid but too far: distance test wins
    send_beat(1'b0, 18'sd0, 1'b0, 31'd0, 31'd1000, 6'd0, 6'd0);
    send_beat(1'b0, 18'sd5, 1'b1, 31'd1020, 31'd1100, 6'd0, 6'd0);      // bins 63 and 68
    send_beat(1'b0, 18'sd5, 1'b1, 31'd1024, 31'd1100, 6'd0, 6'd0);      // row out of range
    send_beat(1'b0, 18'sd5, 1'b1, 31'h7FFF_FF00, 31'h7FFF_FFFF, 6'd0, 6'd0);
    send_beat(1'b1, 18'sd0, 1'b0, 31'd0, 31'd0, 6'd0, 6'd1);            // read and clear
    send_beat(1'b1, 18'sd0, 1'b0, 31'd0, 31'd0, 6'd0, 6'd1);            // now empty
    send_beat(1'b1, 18'sd0, 1'b0, 31'd0, 31'd0, 6'd63, 6'd63);
    send_beat(1'b1, 18'sd0, 1'b0, 31'd0, 31'd0, 6'd63, 6'd6);
    drain();
    // limits off, bin width at its smallest
    apply_setting(1'b1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(1'b0, -18'sd1, 1'b1, 31'd63, 31'd0, 6'd0, 6'd0);
    send_beat(1'b0, -18'sd131072, 1'b1, 31'd63, 31'd0, 6'd0, 6'd0);
    send_beat(1'b0, 18'sd0, 1'b1, 31'd64, 31'd0, 6'd0, 6'd0);
    send_beat(1'b1, 18'sd0, 1'b0, 31'd0, 31'd0, 6'd63, 6'd0);
    drain();

    // random part: two settings per idle pattern, draining between them
    for (int s = 0; s < SEGMENTS; s++) begin
      case (s / 2)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      apply_setting(in_set[s], bw_set[s], mn_set[s], mx_set[s]);
      for (int i = 0; i < RANDOM_ITEMS / SEGMENTS; i++) random_beat();
      drain();
    end

    $display("covered %0d counted pairs and %0d cell reads over %0d register settings",
             counted_pairs, cell_reads, SEGMENTS + 2);
    $display("idle patterns: sender-heavy, receiver-heavy and none");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
